>>> hw/rtl/line_sensor_minmax_normalizer_unit_defines.svh
// Assertion macros shared by the line sensor normalizer RTL.
`ifndef LINE_SENSOR_MINMAX_NORMALIZER_UNIT_DEFINES_SVH
`define LINE_SENSOR_MINMAX_NORMALIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LSMN_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lsmn assertion failed");
`define LSMN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsmn assertion failed");
`define LSMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsmn assertion failed");
`else
`define LSMN_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define LSMN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LSMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/lsmn_pkg.sv
// Constants and types for the line sensor min/max normalizer.
`timescale 1ns / 1ps
package lsmn_pkg;

    localparam int unsigned CHANNELS  = 5;
    localparam int unsigned CH_W      = 3;
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned MIN_W     = SAMPLE_W + 1;
    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned SCALE_TOP = 1000;
    localparam int unsigned QUOT_W    = $clog2(SCALE_TOP + 1);
    localparam int unsigned NUM_W     = SAMPLE_W + QUOT_W;
    localparam int unsigned CNT_W     = $clog2(QUOT_W + 1);

    localparam logic [MIN_W-1:0]  MIN_RESET = MIN_W'(4096);
    localparam logic [QUOT_W-1:0] SCALE_Q   = QUOT_W'(SCALE_TOP);

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_CALIB  = 2'd1;
    localparam logic [1:0] KIND_FIRST  = 2'd2;
    localparam logic [1:0] KIND_SECOND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_DIV,
        MODE_ZERO,
        MODE_FULL
    } map_mode_t;

endpackage

>>> hw/rtl/lsmn_if.sv
// Valid/ready channel interfaces for sensor passes and normalized levels.
`timescale 1ns / 1ps
interface lsmn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] sample_0;
    logic [11:0] sample_1;
    logic [11:0] sample_2;
    logic [11:0] sample_3;
    logic [11:0] sample_4;

    modport source (
        output valid, kind, sample_0, sample_1, sample_2, sample_3, sample_4,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_0, sample_1, sample_2, sample_3, sample_4,
        output ready
    );
endinterface

interface lsmn_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] level_0;
    logic [9:0] level_1;
    logic [9:0] level_2;
    logic [9:0] level_3;
    logic [9:0] level_4;

    modport source (
        output valid, level_0, level_1, level_2, level_3, level_4,
        input  ready
    );
    modport sink (
        input  valid, level_0, level_1, level_2, level_3, level_4,
        output ready
    );
endinterface

>>> hw/rtl/line_sensor_minmax_normalizer_unit.sv
// Five-channel line sensor min/max calibrator and normalizer, top level.
// Channels: samples (sink) carries kind and five 12-bit readings; levels
// (source) carries five 10-bit normalized levels. Both are valid/ready, a
// transfer happens when valid and ready are high at a rising clk edge.
// Kind 0 clears the min/max window, kind 1 widens it, kind 2 maps the
// readings and holds them, kind 3 maps again and sends the floor average
// of both passes as one levels transfer. Only kind 3 produces output.
// Sequence: kinds 0 and 1 update the window on accept and finish. Kinds 2
// and 3 run each channel in turn through one multiply step, ten
// restoring-division steps through a single shared subtract/compare unit
// and one store step. samples.ready is high only between passes.
// A kind 3 result sits in an output register; the next pass is accepted
// while it waits, and that pass only waits at its own end if its result
// would overwrite one not yet taken.
// Reset (rst_n low, async): window goes to min 4096 / max 0, levels.valid
// drops. The held first-pass values are not cleared.
`timescale 1ns / 1ps
`include "line_sensor_minmax_normalizer_unit_defines.svh"
module line_sensor_minmax_normalizer_unit (
    input  logic             clk,
    input  logic             rst_n,
    lsmn_in_if.sink          samples,
    lsmn_out_if.source       levels
);

    lsmn_pkg::state_t state_reg, state_next;

    logic [1:0]                     kind_reg, kind_next;
    logic [lsmn_pkg::SAMPLE_W-1:0]  samp_reg [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::SAMPLE_W-1:0]  samp_next [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::MIN_W-1:0]     min_reg [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::MIN_W-1:0]     min_next [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::SAMPLE_W-1:0]  max_reg [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::SAMPLE_W-1:0]  max_next [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::LEVEL_W-1:0]   first_reg [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::LEVEL_W-1:0]   first_next [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::LEVEL_W-1:0]   res_reg [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::LEVEL_W-1:0]   res_next [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::LEVEL_W-1:0]   out_reg [lsmn_pkg::CHANNELS];
    logic [lsmn_pkg::LEVEL_W-1:0]   out_next [lsmn_pkg::CHANNELS];
    logic                           out_valid_reg, out_valid_next;

    logic [lsmn_pkg::CH_W-1:0]      ch_reg, ch_next;
    logic [lsmn_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    lsmn_pkg::map_mode_t            mode_reg, mode_next;
    logic [lsmn_pkg::SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [lsmn_pkg::SAMPLE_W-1:0]  den_reg, den_next;
    logic [lsmn_pkg::QUOT_W-1:0]    quo_reg, quo_next;

    // per-channel window lookup for the load step
    logic [lsmn_pkg::MIN_W-1:0]     lo;
    logic [lsmn_pkg::MIN_W-1:0]     hi;
    logic [lsmn_pkg::MIN_W-1:0]     xv;
    logic [lsmn_pkg::SAMPLE_W-1:0]  diff;
    logic [lsmn_pkg::NUM_W-1:0]     prod;

    // shared divide step
    logic [lsmn_pkg::MIN_W-1:0]     trial;
    logic                           trial_ge;
    logic [lsmn_pkg::MIN_W-1:0]     trial_sub;

    logic [lsmn_pkg::QUOT_W-1:0]    q_final;
    logic [lsmn_pkg::LEVEL_W:0]     avg_sum;
    logic                           out_free;
    logic                           last_step;
    logic                           last_ch;

    assign lo        = min_reg[ch_reg];
    assign hi        = {1'b0, max_reg[ch_reg]};
    assign xv        = {1'b0, samp_reg[ch_reg]};
    assign diff      = lsmn_pkg::SAMPLE_W'(xv - lo);
    assign prod      = lsmn_pkg::NUM_W'(diff) * lsmn_pkg::NUM_W'(lsmn_pkg::SCALE_Q);

    assign trial     = {rem_reg, quo_reg[lsmn_pkg::QUOT_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb
    begin
        case (mode_reg)
            lsmn_pkg::MODE_ZERO: q_final = '0;
            lsmn_pkg::MODE_FULL: q_final = lsmn_pkg::SCALE_Q;
            default:             q_final = quo_reg;
        endcase
    end

    assign avg_sum   = {1'b0, first_reg[ch_reg]}
                     + {1'b0, lsmn_pkg::LEVEL_W'(q_final)};
    assign out_free  = !out_valid_reg || levels.ready;
    assign last_step = cnt_reg == lsmn_pkg::CNT_W'(lsmn_pkg::QUOT_W - 1);
    assign last_ch   = ch_reg == lsmn_pkg::CH_W'(lsmn_pkg::CHANNELS - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsmn_pkg::ST_IDLE:
            begin
                if (samples.valid)
                begin
                    if (samples.kind == lsmn_pkg::KIND_CLEAR
                        || samples.kind == lsmn_pkg::KIND_CALIB)
                        state_next = lsmn_pkg::ST_DONE;
                    else
                        state_next = lsmn_pkg::ST_LOAD;
                end
            end
            lsmn_pkg::ST_LOAD:
                state_next = lsmn_pkg::ST_DIV;
            lsmn_pkg::ST_DIV:
            begin
                if (last_step)
                    state_next = lsmn_pkg::ST_STORE;
            end
            lsmn_pkg::ST_STORE:
            begin
                if (last_ch)
                    state_next = lsmn_pkg::ST_DONE;
                else
                    state_next = lsmn_pkg::ST_LOAD;
            end
            lsmn_pkg::ST_DONE:
            begin
                if (kind_reg != lsmn_pkg::KIND_SECOND || out_free)
                    state_next = lsmn_pkg::ST_IDLE;
            end
            default:
                state_next = lsmn_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        samples.ready  = state_reg == lsmn_pkg::ST_IDLE;
        levels.valid   = out_valid_reg;
        levels.level_0 = out_reg[0];
        levels.level_1 = out_reg[1];
        levels.level_2 = out_reg[2];
        levels.level_3 = out_reg[3];
        levels.level_4 = out_reg[4];
    end

    // datapath
    always_comb
    begin
        kind_next      = kind_reg;
        samp_next      = samp_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;

        if (out_valid_reg && levels.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            lsmn_pkg::ST_IDLE:
            begin
                if (samples.valid)
                begin
                    kind_next    = samples.kind;
                    samp_next[0] = samples.sample_0;
                    samp_next[1] = samples.sample_1;
                    samp_next[2] = samples.sample_2;
                    samp_next[3] = samples.sample_3;
                    samp_next[4] = samples.sample_4;
                    ch_next      = '0;
                    for (int i = 0; i < lsmn_pkg::CHANNELS; i++)
                    begin
                        if (samples.kind == lsmn_pkg::KIND_CLEAR)
                        begin
                            min_next[i] = lsmn_pkg::MIN_RESET;
                            max_next[i] = '0;
                        end
                        else if (samples.kind == lsmn_pkg::KIND_CALIB)
                        begin
                            if (max_reg[i] < samp_next[i])
                                max_next[i] = samp_next[i];
                            if (min_reg[i] > {1'b0, samp_next[i]})
                                min_next[i] = {1'b0, samp_next[i]};
                        end
                    end
                end
            end
            lsmn_pkg::ST_LOAD:
            begin
                if (hi <= lo || xv <= lo)
                    mode_next = lsmn_pkg::MODE_ZERO;
                else if (xv >= hi)
                    mode_next = lsmn_pkg::MODE_FULL;
                else
                    mode_next = lsmn_pkg::MODE_DIV;
                // num < den * SCALE_TOP, so the top part already sits below den
                rem_next = prod[lsmn_pkg::NUM_W-1:lsmn_pkg::QUOT_W];
                quo_next = prod[lsmn_pkg::QUOT_W-1:0];
                den_next = lsmn_pkg::SAMPLE_W'(hi - lo);
                cnt_next = '0;
            end
            lsmn_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? trial_sub[lsmn_pkg::SAMPLE_W-1:0]
                                    : trial[lsmn_pkg::SAMPLE_W-1:0];
                quo_next = {quo_reg[lsmn_pkg::QUOT_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            lsmn_pkg::ST_STORE:
            begin
                if (kind_reg == lsmn_pkg::KIND_FIRST)
                    first_next[ch_reg] = lsmn_pkg::LEVEL_W'(q_final);
                else
                    res_next[ch_reg] = avg_sum[lsmn_pkg::LEVEL_W:1];
                ch_next = ch_reg + 1'b1;
            end
            lsmn_pkg::ST_DONE:
            begin
                if (kind_reg == lsmn_pkg::KIND_SECOND && out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsmn_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= lsmn_pkg::KIND_CLEAR;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < lsmn_pkg::CHANNELS; i++)
            begin
                min_reg[i] <= lsmn_pkg::MIN_RESET;
                max_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg  <= samp_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        mode_reg  <= mode_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
    end

    `LSMN_ASSERT_NEXT(a_transfer_leaves_idle, clk, rst_n, samples.valid && samples.ready, state_reg != lsmn_pkg::ST_IDLE)
    `LSMN_ASSERT_IMPL(a_quot_in_range, clk, rst_n, state_reg == lsmn_pkg::ST_STORE && mode_reg == lsmn_pkg::MODE_DIV, quo_reg < lsmn_pkg::SCALE_Q)
    `LSMN_ASSERT_IMPL(a_rem_below_den, clk, rst_n, state_reg == lsmn_pkg::ST_DIV && mode_reg == lsmn_pkg::MODE_DIV, rem_reg < den_reg)
    `LSMN_ASSERT_IMPL(a_result_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == lsmn_pkg::ST_DONE))

endmodule
